FILE: src/trfp_pkg.sv
package trfp_pkg;

  localparam int unsigned MAX_BODY_BYTES = 4096;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned HLEN_W   = 16;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0]  MAXLEN_RESET      = 13'd4096;
  localparam logic [BYTE_W-1:0] SYNC_RESET        = 8'h5a;
  localparam logic [BYTE_W-1:0] TAG_RESET         = 8'h40;
  localparam logic [HLEN_W-1:0] TOUCH_PAYLOAD_LEN = 16'd5;
  localparam logic [BYTE_W-1:0] TOUCH_CLASS       = 8'd1;
  localparam logic [LEN_W-1:0]  MIN_BODY_LEN      = 13'd4;
  localparam logic [LEN_W-1:0]  MIN_TOUCH_LEN     = 13'd9;
  localparam logic [HLEN_W-1:0] MAX_BODY_LEN      = HLEN_W'(MAX_BODY_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BODY_LEN = 2'd0,
    CFG_SYNC_VALUE   = 2'd1,
    CFG_TOUCH_TAG    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_TOUCH_OK  = 3'd0,
    ST_BAD_SYNC  = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_TOUCH = 3'd3,
    ST_NON_TOUCH = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    BI_CLASS   = 4'd0,
    BI_PLEN_LO = 4'd1,
    BI_PLEN_HI = 4'd2,
    BI_CONTENT = 4'd3,
    BI_FLAGS   = 4'd4,
    BI_X_LO    = 4'd5,
    BI_X_HI    = 4'd6,
    BI_Y_LO    = 4'd7,
    BI_Y_HI    = 4'd8
  } body_idx_t;

endpackage

FILE: src/touch_report_frame_parser.sv
// Path: the last byte of a frame (or header byte three on a header error) passes the
// input stage, and its result is then registered in the output register (out_valid).
// Throughput: one byte per cycle; the input stage holds a byte only while it carries
// a result and the output register is full and stalled.
// Reset (synchronous, rst_n low): configuration returns to its defaults, the parser
// expects a header byte zero, and the input and output stages are empty.
module touch_report_frame_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [trfp_pkg::BYTE_W-1:0]        in_rx_byte,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_frame_status,
  output logic [trfp_pkg::BYTE_W-1:0]        out_class_code,
  output logic                               out_touch_down,
  output logic [trfp_pkg::POS_W-1:0]         out_pos_x,
  output logic [trfp_pkg::POS_W-1:0]         out_pos_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [trfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trfp_pkg::LEN_W-1:0]         cfg_wdata
);
  import trfp_pkg::*;

  logic [LEN_W-1:0]  max_len_r;
  logic [BYTE_W-1:0] sync_r;
  logic [BYTE_W-1:0] tag_r;

  logic              s1_vld_r, s1_vld_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;

  logic              in_body_r, in_body_nxt;
  logic [LEN_W-1:0]  byte_index_r, byte_index_nxt;
  logic [BYTE_W-1:0] hdr1_r, hdr1_nxt;
  logic [5:0]        hdr2_r, hdr2_nxt;
  logic [LEN_W-1:0]  body_len_r, body_len_nxt;
  logic [BYTE_W-1:0] class_r, class_nxt;
  logic [HLEN_W-1:0] plen_r, plen_nxt;
  logic [BYTE_W-1:0] content_r, content_nxt;
  logic              flag_r, flag_nxt;
  logic [POS_W-1:0]  x_r, x_nxt;
  logic [POS_W-1:0]  y_r, y_nxt;

  logic              out_vld_r, out_vld_nxt;
  status_t           out_status_r, res_status;
  logic [BYTE_W-1:0] out_class_r, res_class;
  logic              out_td_r, res_td;
  logic [POS_W-1:0]  out_x_r, res_x;
  logic [POS_W-1:0]  out_y_r, res_y;

  logic              in_acc;
  logic              s1_go;
  logic              res_valid;
  logic [LEN_W-1:0]  idx;
  logic [HLEN_W-1:0] hdr_len;
  logic [LEN_W:0]    idx_inc;
  logic              touch_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAXLEN_RESET;
      sync_r    <= SYNC_RESET;
      tag_r     <= TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_BODY_LEN: max_len_r <= cfg_wdata;
        CFG_SYNC_VALUE:   sync_r    <= cfg_wdata[BYTE_W-1:0];
        CFG_TOUCH_TAG:    tag_r     <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go    = s1_vld_r && (!res_valid || !out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  assign idx     = s1_start_r ? '0 : byte_index_r;
  assign hdr_len = {hdr2_r, hdr1_r, 2'b00};
  assign idx_inc = {1'b0, idx} + (LEN_W+1)'(1);

  always_comb begin
    in_body_nxt    = in_body_r;
    byte_index_nxt = byte_index_r;
    hdr1_nxt       = hdr1_r;
    hdr2_nxt       = hdr2_r;
    body_len_nxt   = body_len_r;
    class_nxt      = class_r;
    plen_nxt       = plen_r;
    content_nxt    = content_r;
    flag_nxt       = flag_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    res_valid      = 1'b0;
    res_status     = ST_TOUCH_OK;
    res_class      = '0;
    res_td         = 1'b0;
    res_x          = '0;
    res_y          = '0;
    touch_ok       = 1'b0;
    if (s1_start_r || !in_body_r) begin
      in_body_nxt = 1'b0;
      case (idx[1:0])
        2'd0: begin
          byte_index_nxt = LEN_W'(1);
        end
        2'd1: begin
          hdr1_nxt       = s1_byte_r;
          byte_index_nxt = LEN_W'(2);
        end
        2'd2: begin
          hdr2_nxt       = s1_byte_r[5:0];
          byte_index_nxt = LEN_W'(3);
        end
        default: begin
          byte_index_nxt = '0;
          if (s1_byte_r != sync_r) begin
            res_valid  = 1'b1;
            res_status = ST_BAD_SYNC;
          end else if (hdr_len < HLEN_W'(MIN_BODY_LEN) ||
                       hdr_len > {{(HLEN_W-LEN_W){1'b0}}, max_len_r} ||
                       hdr_len > MAX_BODY_LEN) begin
            res_valid  = 1'b1;
            res_status = ST_BAD_LEN;
          end else begin
            in_body_nxt  = 1'b1;
            body_len_nxt = hdr_len[LEN_W-1:0];
          end
        end
      endcase
    end else begin
      case (idx)
        LEN_W'(BI_CLASS): begin
          class_nxt   = s1_byte_r;
          plen_nxt    = '0;
          content_nxt = '0;
          flag_nxt    = 1'b0;
          x_nxt       = '0;
          y_nxt       = '0;
        end
        LEN_W'(BI_PLEN_LO): plen_nxt    = {8'd0, s1_byte_r};
        LEN_W'(BI_PLEN_HI): plen_nxt    = {s1_byte_r, plen_r[7:0]};
        LEN_W'(BI_CONTENT): content_nxt = s1_byte_r;
        LEN_W'(BI_FLAGS):   flag_nxt    = s1_byte_r[0];
        LEN_W'(BI_X_LO):    x_nxt       = {x_r[POS_W-1:3], s1_byte_r[7:5]};
        LEN_W'(BI_X_HI):    x_nxt       = {s1_byte_r, x_r[2:0]};
        LEN_W'(BI_Y_LO):    y_nxt       = {y_r[POS_W-1:3], s1_byte_r[7:5]};
        LEN_W'(BI_Y_HI):    y_nxt       = {s1_byte_r, y_r[2:0]};
        default: ;
      endcase
      if (idx_inc < {1'b0, body_len_r}) begin
        byte_index_nxt = idx_inc[LEN_W-1:0];
      end else begin
        in_body_nxt    = 1'b0;
        byte_index_nxt = '0;
        res_valid      = 1'b1;
        res_class      = class_nxt;
        touch_ok       = body_len_r >= MIN_TOUCH_LEN && plen_nxt == TOUCH_PAYLOAD_LEN &&
                         content_nxt == tag_r;
        if (class_nxt != TOUCH_CLASS) begin
          res_status = ST_NON_TOUCH;
        end else if (!touch_ok) begin
          res_status = ST_BAD_TOUCH;
        end else begin
          res_status = ST_TOUCH_OK;
          res_td     = flag_nxt;
          if (flag_nxt) begin
            res_x = x_nxt;
            res_y = y_nxt;
          end
        end
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_go && res_valid) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      in_body_r    <= 1'b0;
      byte_index_r <= '0;
      hdr1_r       <= '0;
      hdr2_r       <= '0;
      body_len_r   <= '0;
      class_r      <= '0;
      plen_r       <= '0;
      content_r    <= '0;
      flag_r       <= 1'b0;
      x_r          <= '0;
      y_r          <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_go) begin
        in_body_r    <= in_body_nxt;
        byte_index_r <= byte_index_nxt;
        hdr1_r       <= hdr1_nxt;
        hdr2_r       <= hdr2_nxt;
        body_len_r   <= body_len_nxt;
        class_r      <= class_nxt;
        plen_r       <= plen_nxt;
        content_r    <= content_nxt;
        flag_r       <= flag_nxt;
        x_r          <= x_nxt;
        y_r          <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
    if (s1_go && res_valid) begin
      out_status_r <= res_status;
      out_class_r  <= res_class;
      out_td_r     <= res_td;
      out_x_r      <= res_x;
      out_y_r      <= res_y;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_frame_status = out_status_r;
  assign out_class_code   = out_class_r;
  assign out_touch_down   = out_td_r;
  assign out_pos_x        = out_x_r;
  assign out_pos_y        = out_y_r;

`ifndef SYNTHESIS
  a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> byte_index_r < body_len_r)
    else $error("body byte index beyond body length");

  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    !in_body_r |-> byte_index_r < LEN_W'(4))
    else $error("header byte index out of range");

  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (body_len_r >= MIN_BODY_LEN &&
                   {{(HLEN_W-LEN_W){1'b0}}, body_len_r} <= MAX_BODY_LEN))
    else $error("body length outside accepted range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && res_valid && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status != ST_TOUCH_OK) |->
      (!out_touch_down && out_pos_x == '0 && out_pos_y == '0))
    else $error("error result carries touch data");
`endif

endmodule
